/* design/udpd_pkg.sv */
`default_nettype none
package udpd_pkg;

  typedef enum logic [3:0] {
    ST_BOUND        = 4'd0,
    ST_PORT_ZERO    = 4'd1,
    ST_ALREADY      = 4'd2,
    ST_FULL         = 4'd3,
    ST_UNBOUND      = 4'd4,
    ST_NOT_FOUND    = 4'd5,
    ST_DELIVERED    = 4'd6,
    ST_NO_HANDLER   = 4'd7,
    ST_TOO_SHORT    = 4'd8,
    ST_LEN_MISMATCH = 4'd9,
    ST_NO_LISTENER  = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    CMD_BIND,
    CMD_UNBIND,
    CMD_PACKET,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic [15:0] port;
    logic [7:0]  handler;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [15:0] payload;
  } cmd_t;

endpackage
`default_nettype wire

/* design/udpd_front.sv */
`default_nettype none
module udpd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      in_req_type,
  input  wire logic [15:0]     in_port,
  input  wire logic [7:0]      in_handler_id,
  input  wire logic [31:0]     in_src_ip,
  input  wire logic [15:0]     in_hdr_src_port_raw,
  input  wire logic [15:0]     in_hdr_dst_port_raw,
  input  wire logic [15:0]     in_hdr_length_raw,
  input  wire logic [15:0]     in_packet_length,
  input  wire logic            init,
  input  wire logic            q_full,
  output logic                 q_push,
  output udpd_pkg::cmd_t       q_cmd
);

  localparam logic [1:0] REQ_BIND   = 2'd0;
  localparam logic [1:0] REQ_UNBIND = 2'd1;
  localparam logic [1:0] REQ_PACKET = 2'd2;

  logic           fv_r, fv_nxt;
  udpd_pkg::cmd_t fcmd_r;
  udpd_pkg::cmd_t cmd;
  logic           acc;
  logic [15:0]    srcp, dstp, ulen;

  assign busy   = init || (fv_r && q_full);
  assign acc    = start && !busy;
  assign q_push = fv_r && !q_full;
  assign q_cmd  = fcmd_r;

  assign srcp = {in_hdr_src_port_raw[7:0], in_hdr_src_port_raw[15:8]};
  assign dstp = {in_hdr_dst_port_raw[7:0], in_hdr_dst_port_raw[15:8]};
  assign ulen = {in_hdr_length_raw[7:0], in_hdr_length_raw[15:8]};

  // classify: answers that need no table lookup are settled here
  always_comb begin
    cmd = '0;
    case (in_req_type)
      REQ_BIND: begin
        cmd.port    = in_port;
        cmd.handler = in_handler_id;
        if (in_port == 16'd0) begin
          cmd.kind   = udpd_pkg::CMD_REPORT;
          cmd.status = udpd_pkg::ST_PORT_ZERO;
        end else begin
          cmd.kind = udpd_pkg::CMD_BIND;
        end
      end
      REQ_UNBIND: begin
        cmd.kind = udpd_pkg::CMD_UNBIND;
        cmd.port = in_port;
      end
      REQ_PACKET: begin
        if (in_packet_length < 16'd8) begin
          cmd.kind   = udpd_pkg::CMD_REPORT;
          cmd.status = udpd_pkg::ST_TOO_SHORT;
        end else if (ulen > in_packet_length) begin
          cmd.kind   = udpd_pkg::CMD_REPORT;
          cmd.status = udpd_pkg::ST_LEN_MISMATCH;
        end else begin
          cmd.kind     = udpd_pkg::CMD_PACKET;
          cmd.port     = dstp;
          cmd.src_ip   = in_src_ip;
          cmd.sport    = srcp;
          cmd.payload  = ulen - 16'd8;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    fv_nxt = fv_r;
    if (acc) begin
      fv_nxt = (in_req_type == REQ_BIND) || (in_req_type == REQ_UNBIND) ||
               (in_req_type == REQ_PACKET);
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fcmd_r <= cmd;
    end
  end

endmodule
`default_nettype wire

/* design/udpd_queue.sv */
`default_nettype none
module udpd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire udpd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output udpd_pkg::cmd_t      head
);

  udpd_pkg::cmd_t q_mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* design/udpd_back.sv */
`default_nettype none
module udpd_back #(
  parameter int SOCKET_SLOTS = 128,
  parameter int HANDLER_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  output logic                init,
  input  wire logic           q_empty,
  input  wire udpd_pkg::cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  output logic [3:0]          out_status,
  output logic [6:0]          out_slot_index,
  output logic [7:0]          out_handler_out,
  output logic [31:0]         out_src_ip_out,
  output logic [15:0]         out_src_port_out,
  output logic [15:0]         out_payload_length
);

  localparam int IW = (SOCKET_SLOTS > 1) ? $clog2(SOCKET_SLOTS) : 1;
  localparam int CW = $clog2(SOCKET_SLOTS + 1);
  localparam int SW = 17 + HANDLER_BITS;
  localparam logic [IW-1:0] LAST_IDX  = IW'(SOCKET_SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_CNT = CW'(SOCKET_SLOTS);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_SCAN} state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]         chk_idx_r, chk_idx_nxt;
  udpd_pkg::cmd_t        cmd_r, cmd_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IW-1:0]         free_idx_r, free_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  udpd_pkg::status_t     out_status_r, out_status_nxt;
  logic [6:0]            out_slot_r, out_slot_nxt;
  logic [7:0]            out_handler_r, out_handler_nxt;
  logic [31:0]           out_src_ip_r, out_src_ip_nxt;
  logic [15:0]           out_src_port_r, out_src_port_nxt;
  logic [15:0]           out_payload_r, out_payload_nxt;

  logic [SW-1:0]         mem [SOCKET_SLOTS];
  logic [SW-1:0]         rd_q;
  logic                  mem_we, rd_en;
  logic [IW-1:0]         mem_wa, rd_addr;
  logic [SW-1:0]         mem_wd;

  logic                  rd_active;
  logic [15:0]           rd_port;
  logic [HANDLER_BITS-1:0] rd_handler;
  logic                  hit, last, cur_free, free_any;
  logic [IW-1:0]         free_sel;
  logic [31:0]           chk_idx_ext, free_sel_ext, rd_handler_ext, cmd_handler_ext;
  logic [HANDLER_BITS-1:0] h_store;

  assign rd_active  = rd_q[SW-1];
  assign rd_port    = rd_q[SW-2 -: 16];
  assign rd_handler = rd_q[HANDLER_BITS-1:0];

  assign hit      = chk_vld_r && rd_active && (rd_port == cmd_r.port);
  assign last     = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign cur_free = chk_vld_r && !rd_active;
  assign free_any = free_found_r || cur_free;
  assign free_sel = free_found_r ? free_idx_r : chk_idx_r;

  assign chk_idx_ext     = 32'(chk_idx_r);
  assign free_sel_ext    = 32'(free_sel);
  assign rd_handler_ext  = 32'(rd_handler);
  assign cmd_handler_ext = 32'(cmd_r.handler);
  assign h_store         = cmd_handler_ext[HANDLER_BITS-1:0];

  assign init               = (state_r == S_INIT);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_r;
  assign out_handler_out    = out_handler_r;
  assign out_src_ip_out     = out_src_ip_r;
  assign out_src_port_out   = out_src_port_r;
  assign out_payload_length = out_payload_r;

  always_comb begin
    state_nxt        = state_r;
    rd_idx_nxt       = rd_idx_r;
    chk_vld_nxt      = chk_vld_r;
    chk_idx_nxt      = chk_idx_r;
    cmd_nxt          = cmd_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = udpd_pkg::ST_BOUND;
    out_slot_nxt     = '0;
    out_handler_nxt  = '0;
    out_src_ip_nxt   = '0;
    out_src_port_nxt = '0;
    out_payload_nxt  = '0;
    mem_we           = 1'b0;
    mem_wa           = chk_idx_r;
    mem_wd           = '0;
    rd_en            = 1'b0;
    rd_addr          = rd_idx_r[IW-1:0];
    q_pop            = 1'b0;

    case (state_r)
      S_INIT: begin
        // clearing pass, one slot per cycle
        mem_we     = 1'b1;
        mem_wa     = rd_idx_r[IW-1:0];
        rd_idx_nxt = rd_idx_r + CW'(1);
        if (rd_idx_r[IW-1:0] == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (q_head.kind == udpd_pkg::CMD_REPORT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = q_head.status;
          end else begin
            state_nxt      = S_SCAN;
            rd_en          = 1'b1;
            rd_addr        = '0;
            rd_idx_nxt     = CW'(1);
            chk_vld_nxt    = 1'b1;
            chk_idx_nxt    = '0;
            free_found_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // reads run one slot ahead of the compare
        if (rd_idx_r != SLOTS_CNT) begin
          rd_en       = 1'b1;
          rd_addr     = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (cur_free && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (hit) begin
          state_nxt     = S_IDLE;
          chk_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          case (cmd_r.kind)
            udpd_pkg::CMD_BIND: begin
              out_status_nxt = udpd_pkg::ST_ALREADY;
            end
            udpd_pkg::CMD_UNBIND: begin
              mem_we         = 1'b1;
              mem_wa         = chk_idx_r;
              mem_wd         = {1'b0, rd_port, rd_handler};
              out_status_nxt = udpd_pkg::ST_UNBOUND;
              out_slot_nxt   = chk_idx_ext[6:0];
            end
            udpd_pkg::CMD_PACKET: begin
              out_status_nxt   = (rd_handler != '0) ? udpd_pkg::ST_DELIVERED
                                                    : udpd_pkg::ST_NO_HANDLER;
              out_slot_nxt     = chk_idx_ext[6:0];
              out_handler_nxt  = rd_handler_ext[7:0];
              out_src_ip_nxt   = cmd_r.src_ip;
              out_src_port_nxt = cmd_r.sport;
              out_payload_nxt  = cmd_r.payload;
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end else if (last) begin
          state_nxt     = S_IDLE;
          chk_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          case (cmd_r.kind)
            udpd_pkg::CMD_BIND: begin
              if (free_any) begin
                mem_we         = 1'b1;
                mem_wa         = free_sel;
                mem_wd         = {1'b1, cmd_r.port, h_store};
                out_status_nxt = udpd_pkg::ST_BOUND;
                out_slot_nxt   = free_sel_ext[6:0];
              end else begin
                out_status_nxt = udpd_pkg::ST_FULL;
              end
            end
            udpd_pkg::CMD_UNBIND: out_status_nxt = udpd_pkg::ST_NOT_FOUND;
            udpd_pkg::CMD_PACKET: out_status_nxt = udpd_pkg::ST_NO_LISTENER;
            default:              out_valid_nxt  = 1'b0;
          endcase
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      rd_idx_r     <= '0;
      chk_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    chk_idx_r      <= chk_idx_nxt;
    cmd_r          <= cmd_nxt;
    free_idx_r     <= free_idx_nxt;
    out_status_r   <= out_status_nxt;
    out_slot_r     <= out_slot_nxt;
    out_handler_r  <= out_handler_nxt;
    out_src_ip_r   <= out_src_ip_nxt;
    out_src_port_r <= out_src_port_nxt;
    out_payload_r  <= out_payload_nxt;
  end

  // slot table: active flag, port, handler
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/udp_port_demux_table.sv */
`default_nettype none
// UDP port binding table. Items enter on start while busy is low; each bind, unbind
// or packet item yields one result, shown on the out_ ports for exactly one cycle
// with out_valid high; the receiver cannot stall, so results must be taken when
// shown. Request type 3 yields no result. A slot memory with one read and one write
// port is scanned one slot per cycle: a bind that finds no match scans all
// SOCKET_SLOTS slots, an unbind or packet stops at the matching slot, and a bind
// of port 0 or a packet that fails the length checks is answered without a scan.
// A two-entry queue between the classifying front end and the table engine lets
// a new item be taken while a scan runs. After reset the table is cleared slot by
// slot, during which busy is high.
module udp_port_demux_table #(
  parameter int SOCKET_SLOTS = 128,
  parameter int HANDLER_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_port,
  input  wire logic [7:0]  in_handler_id,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [15:0] in_hdr_src_port_raw,
  input  wire logic [15:0] in_hdr_dst_port_raw,
  input  wire logic [15:0] in_hdr_length_raw,
  input  wire logic [15:0] in_packet_length,
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic [6:0]       out_slot_index,
  output logic [7:0]       out_handler_out,
  output logic [31:0]      out_src_ip_out,
  output logic [15:0]      out_src_port_out,
  output logic [15:0]      out_payload_length
);

  logic           init;
  logic           q_full, q_empty, q_push, q_pop;
  udpd_pkg::cmd_t q_cmd, q_head;

  udpd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_port             (in_port),
    .in_handler_id       (in_handler_id),
    .in_src_ip           (in_src_ip),
    .in_hdr_src_port_raw (in_hdr_src_port_raw),
    .in_hdr_dst_port_raw (in_hdr_dst_port_raw),
    .in_hdr_length_raw   (in_hdr_length_raw),
    .in_packet_length    (in_packet_length),
    .init                (init),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (q_cmd)
  );

  udpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  udpd_back #(
    .SOCKET_SLOTS (SOCKET_SLOTS),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .init               (init),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_handler_out    (out_handler_out),
    .out_src_ip_out     (out_src_ip_out),
    .out_src_port_out   (out_src_port_out),
    .out_payload_length (out_payload_length)
  );

endmodule
`default_nettype wire

/* tb/tb_udp_port_demux_table.sv */
`timescale 1ns / 1ps
module tb_udp_port_demux_table;

  localparam int SLOTS = 128;
  localparam int POOL  = 32;

  typedef struct {
    udpd_pkg::cmd_kind_t kind;
    logic [15:0] port;
    logic [7:0]  handler;
    logic [31:0] src_ip;
    logic [15:0] sport_raw;
    logic [15:0] dport_raw;
    logic [15:0] len_raw;
    logic [15:0] rx_len;
  } demux_req_t;

  typedef struct {
    udpd_pkg::status_t status;
    logic [6:0]  slot;
    logic [7:0]  handler;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [15:0] payload;
  } demux_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_port = '0;
  logic [7:0]  in_handler_id = '0;
  logic [31:0] in_src_ip = '0;
  logic [15:0] in_hdr_src_port_raw = '0;
  logic [15:0] in_hdr_dst_port_raw = '0;
  logic [15:0] in_hdr_length_raw = '0;
  logic [15:0] in_packet_length = '0;
  logic        busy;
  logic        out_valid;
  logic [3:0]  out_status;
  logic [6:0]  out_slot_index;
  logic [7:0]  out_handler_out;
  logic [31:0] out_src_ip_out;
  logic [15:0] out_src_port_out;
  logic [15:0] out_payload_length;

  bit             bound_active  [SLOTS];
  logic [15:0]    bound_port    [SLOTS];
  logic [7:0]     bound_handler [SLOTS];
  demux_verdict_t verdict_q[$];
  logic [15:0]    port_pool [POOL];
  int             status_seen [16];
  int             errors = 0;
  int             accepted = 0;
  int             checked = 0;
  int             idle_pct = 0;

  udp_port_demux_table #(
    .SOCKET_SLOTS(SLOTS),
    .HANDLER_BITS(8)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_port             (in_port),
    .in_handler_id       (in_handler_id),
    .in_src_ip           (in_src_ip),
    .in_hdr_src_port_raw (in_hdr_src_port_raw),
    .in_hdr_dst_port_raw (in_hdr_dst_port_raw),
    .in_hdr_length_raw   (in_hdr_length_raw),
    .in_packet_length    (in_packet_length),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_handler_out     (out_handler_out),
    .out_src_ip_out      (out_src_ip_out),
    .out_src_port_out    (out_src_port_out),
    .out_payload_length  (out_payload_length)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] swap_bytes(logic [15:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  function automatic int lookup_port(logic [15:0] p);
    for (int i = 0; i < SLOTS; i++)
      if (bound_active[i] && bound_port[i] == p) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!bound_active[i]) return i;
    return -1;
  endfunction

  // binding table state advances here, once per accepted request
  function automatic bit resolve_request(demux_req_t r, output demux_verdict_t v);
    int          hit;
    logic [15:0] dst;
    logic [15:0] ulen;
    v = '{udpd_pkg::ST_BOUND, 7'd0, 8'd0, 32'd0, 16'd0, 16'd0};
    hit = lookup_port(r.port);
    case (r.kind)
      udpd_pkg::CMD_BIND: begin
        if (r.port == 16'd0) begin
          v.status = udpd_pkg::ST_PORT_ZERO;
        end else if (hit >= 0) begin
          v.status = udpd_pkg::ST_ALREADY;
        end else begin
          hit = first_free();
          if (hit < 0) begin
            v.status = udpd_pkg::ST_FULL;
          end else begin
            bound_active[hit]  = 1'b1;
            bound_port[hit]    = r.port;
            bound_handler[hit] = r.handler;
            v.slot = 7'(hit);
          end
        end
      end
      udpd_pkg::CMD_UNBIND: begin
        if (hit >= 0) begin
          bound_active[hit] = 1'b0;
          v.status = udpd_pkg::ST_UNBOUND;
          v.slot = 7'(hit);
        end else begin
          v.status = udpd_pkg::ST_NOT_FOUND;
        end
      end
      udpd_pkg::CMD_PACKET: begin
        dst  = swap_bytes(r.dport_raw);
        ulen = swap_bytes(r.len_raw);
        if (r.rx_len < 16'd8) begin
          v.status = udpd_pkg::ST_TOO_SHORT;
        end else if (ulen > r.rx_len) begin
          v.status = udpd_pkg::ST_LEN_MISMATCH;
        end else begin
          hit = lookup_port(dst);
          if (hit < 0) begin
            v.status = udpd_pkg::ST_NO_LISTENER;
          end else begin
            v.slot     = 7'(hit);
            v.handler  = bound_handler[hit];
            v.status   = (bound_handler[hit] != 8'd0) ? udpd_pkg::ST_DELIVERED
                                                      : udpd_pkg::ST_NO_HANDLER;
            v.src_ip   = r.src_ip;
            v.sport    = swap_bytes(r.sport_raw);
            v.payload  = ulen - 16'd8;
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic demux_req_t table_req(udpd_pkg::cmd_kind_t kind, logic [15:0] port,
                                           logic [7:0] handler);
    demux_req_t r;
    r = '{kind, port, handler, 32'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), 16'($urandom)};
    return r;
  endfunction

  function automatic demux_req_t packet_req(logic [15:0] dst, logic [15:0] ulen,
                                            logic [15:0] rx_len);
    demux_req_t r;
    r = table_req(udpd_pkg::CMD_PACKET, 16'($urandom), 8'($urandom));
    r.dport_raw = swap_bytes(dst);
    r.len_raw   = swap_bytes(ulen);
    r.rx_len    = rx_len;
    return r;
  endfunction

  task automatic send_request(demux_req_t r);
    demux_verdict_t v;
    start               <= 1'b1;
    in_req_type         <= r.kind;
    in_port             <= r.port;
    in_handler_id       <= r.handler;
    in_src_ip           <= r.src_ip;
    in_hdr_src_port_raw <= r.sport_raw;
    in_hdr_dst_port_raw <= r.dport_raw;
    in_hdr_length_raw   <= r.len_raw;
    in_packet_length    <= r.rx_len;
    do @(posedge clk); while (busy !== 1'b0);
    accepted++;
    if (resolve_request(r, v)) verdict_q.push_back(v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    demux_verdict_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (verdict_q.size() == 0) begin
        $error("result with no request pending, status %0d", out_status);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        checked++;
        status_seen[want.status]++;
        check_field("status", want.status, out_status);
        check_field("slot_index", want.slot, out_slot_index);
        check_field("handler_out", want.handler, out_handler_out);
        check_field("src_ip_out", want.src_ip, out_src_ip_out);
        check_field("src_port_out", want.sport, out_src_port_out);
        check_field("payload_length", want.payload, out_payload_length);
      end
    end
  end

  task automatic test_directed();
    demux_req_t r;
    idle_pct = 0;
    send_request(table_req(udpd_pkg::CMD_BIND, 16'd0, 8'h55));
    send_request(table_req(udpd_pkg::CMD_UNBIND, 16'h1234, 8'd0));
    send_request(packet_req(16'h1234, 16'd8, 16'd7));
    send_request(packet_req(16'h1234, 16'd0, 16'd0));
    send_request(packet_req(16'h1234, 16'd9, 16'd8));
    send_request(packet_req(16'h1234, 16'd8, 16'd8));
    send_request(table_req(udpd_pkg::CMD_BIND, 16'hFFFF, 8'hFF));
    send_request(table_req(udpd_pkg::CMD_BIND, 16'h0001, 8'h00));
    send_request(table_req(udpd_pkg::CMD_BIND, 16'hFFFF, 8'h01));
    r = packet_req(16'hFFFF, 16'd8, 16'hFFFF);
    r.src_ip    = 32'hFFFF_FFFF;
    r.sport_raw = 16'hFFFF;
    send_request(r);
    r = packet_req(16'hFFFF, 16'hFFFF, 16'hFFFF);
    r.src_ip    = 32'h0000_0000;
    r.sport_raw = 16'h0000;
    send_request(r);
    send_request(packet_req(16'h0001, 16'd0, 16'd8));
    send_request(packet_req(16'h0001, 16'd7, 16'd8));
    r = table_req(udpd_pkg::CMD_REPORT, 16'hFFFF, 8'hFF);
    r.src_ip = 32'hFFFF_FFFF;
    send_request(r);
    send_request(table_req(udpd_pkg::CMD_UNBIND, 16'hFFFF, 8'd0));
    send_request(table_req(udpd_pkg::CMD_BIND, 16'h8000, 8'h80));
    send_request(packet_req(16'h8000, 16'd1500, 16'd1500));
    send_request(packet_req(16'hFFFF, 16'd8, 16'd8));
    send_request(table_req(udpd_pkg::CMD_UNBIND, 16'h0001, 8'd0));
    send_request(table_req(udpd_pkg::CMD_UNBIND, 16'h0001, 8'd0));
    send_request(table_req(udpd_pkg::CMD_UNBIND, 16'h8000, 8'd0));
  endtask

  task automatic test_table_full();
    logic [15:0] p;
    int          victim;
    idle_pct = 35;
    while (first_free() >= 0) begin
      do p = 16'($urandom); while (p == 16'd0 || lookup_port(p) >= 0);
      send_request(table_req(udpd_pkg::CMD_BIND, p,
                             ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom)));
    end
    send_request(table_req(udpd_pkg::CMD_BIND, p ^ 16'h8000, 8'h11));
    send_request(table_req(udpd_pkg::CMD_BIND, bound_port[SLOTS-1], 8'h22));
    send_request(packet_req(bound_port[SLOTS-1], 16'd8, 16'd8));
    send_request(packet_req(bound_port[0], 16'd64, 16'd64));
    victim = $urandom_range(1, SLOTS - 2);
    send_request(table_req(udpd_pkg::CMD_UNBIND, bound_port[victim], 8'd0));
    send_request(table_req(udpd_pkg::CMD_UNBIND, bound_port[0], 8'd0));
    for (int k = 0; k < 3; k++) begin
      do p = 16'($urandom); while (p == 16'd0 || lookup_port(p) >= 0);
      send_request(table_req(udpd_pkg::CMD_BIND, p, 8'($urandom)));
    end
    for (int i = 0; i < SLOTS; i++)
      if (bound_active[i])
        send_request(table_req(udpd_pkg::CMD_UNBIND, bound_port[i], 8'd0));
  endtask

  function automatic demux_req_t random_request();
    int          pick;
    logic [15:0] p;
    logic [15:0] plen;
    logic [15:0] ulen;
    pick = $urandom_range(99);
    p = ($urandom_range(19) == 0) ? 16'($urandom) : port_pool[$urandom_range(POOL - 1)];
    if (pick < 4)
      return table_req(udpd_pkg::CMD_REPORT, p, 8'($urandom));
    if (pick < 32)
      return table_req(udpd_pkg::CMD_BIND, ($urandom_range(24) == 0) ? 16'd0 : p,
                       ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom));
    if (pick < 52)
      return table_req(udpd_pkg::CMD_UNBIND, p, 8'($urandom));
    plen = ($urandom_range(3) == 0) ? 16'($urandom_range(8, 65535))
                                    : 16'($urandom_range(8, 1500));
    case ($urandom_range(9))
      0: begin
        plen = 16'($urandom_range(7));
        ulen = 16'($urandom);
      end
      1: begin
        if (plen == 16'hFFFF) plen = 16'hFFFE;
        ulen = 16'($urandom_range(plen + 1, 65535));
      end
      2: ulen = 16'($urandom_range(7));
      default: ulen = 16'($urandom_range(8, plen));
    endcase
    return packet_req(($urandom_range(9) == 0) ? 16'($urandom) : p, ulen, plen);
  endfunction

  task automatic test_random(int pct, int count);
    demux_req_t r;
    int         n;
    idle_pct = pct;
    n = 0;
    while (n < count) begin
      r = random_request();
      send_request(r);
      if (r.kind != udpd_pkg::CMD_REPORT) n++;
    end
  endtask

  initial begin
    int kinds;
    for (int i = 0; i < POOL; i++) begin
      port_pool[i] = 16'($urandom);
      if (port_pool[i] == 16'd0) port_pool[i] = 16'd1;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random(0, 300);
    test_random(73, 300);
    test_random(35, 300);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 40) @(posedge clk);
    kinds = 0;
    for (int i = 0; i < 16; i++)
      if (status_seen[i] != 0) kinds++;
    $display("%0d requests accepted, %0d results checked, table filled to all %0d slots",
             accepted, checked, SLOTS);
    $display("%0d distinct status codes seen, sender idle at 0, 73 and 35 percent", kinds);
    if (errors == 0) begin
      $display("udp_port_demux_table: match");
    end else begin
      $display("udp_port_demux_table: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("udp_port_demux_table: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/udpd_pkg.sv
design/udpd_front.sv
design/udpd_queue.sv
design/udpd_back.sv
design/udp_port_demux_table.sv
tb/tb_udp_port_demux_table.sv
